// File: rtl/pso_pkg.sv
`default_nettype none

package pso_pkg;

  typedef enum logic [2:0] {
    CMD_SYNC         = 3'd0,
    CMD_FOLLOW_UP    = 3'd1,
    CMD_DELAY_RESP   = 3'd2,
    CMD_DELAY_REQ_TX = 3'd3
  } cmd_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_OFFSET  = 1'b1
  } kind_t;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [7:0]  ID_FILL_HI = 8'hFF;
  localparam logic [7:0]  ID_FILL_LO = 8'hFE;

  typedef struct packed {
    logic upd_sync;
    logic upd_origin;
    logic issue;
    logic upd_departure;
    logic resp;
  } decision_t;

  function automatic logic [63:0] own_identity(input logic [47:0] mac);
    own_identity = {mac[47:24], ID_FILL_HI, ID_FILL_LO, mac[23:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/pso_decide.sv
`default_nettype none

module pso_decide (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire logic [2:0]          cmd,
  input  wire logic [15:0]         sequence_id,
  input  wire logic [63:0]         source_clock,
  input  wire logic [63:0]         requesting_clock,
  input  wire logic [63:0]         own_clock,
  output pso_pkg::decision_t       dec
);

  logic        master_locked;
  logic        master_locked_next;
  logic [63:0] master_identity;
  logic [63:0] master_identity_next;
  logic [15:0] sync_sequence;
  logic [15:0] sync_sequence_next;
  logic [15:0] followup_sequence;
  logic [15:0] followup_sequence_next;
  logic        request_issued;
  logic        request_issued_next;
  logic [63:0] issued_clock;
  logic [63:0] issued_clock_next;

  always_comb begin
    dec                    = '0;
    master_locked_next     = master_locked;
    master_identity_next   = master_identity;
    sync_sequence_next     = sync_sequence;
    followup_sequence_next = followup_sequence;
    request_issued_next    = request_issued;
    issued_clock_next      = issued_clock;
    unique case (pso_pkg::cmd_t'(cmd))
      pso_pkg::CMD_SYNC: begin
        if (!master_locked) begin
          master_locked_next   = 1'b1;
          master_identity_next = source_clock;
        end
        if (!master_locked || source_clock == master_identity) begin
          sync_sequence_next = sequence_id;
          dec.upd_sync       = 1'b1;
        end
      end
      pso_pkg::CMD_FOLLOW_UP: begin
        if (master_locked && source_clock == master_identity) begin
          followup_sequence_next = sequence_id;
          dec.upd_origin         = 1'b1;
          if (sequence_id == sync_sequence) begin
            request_issued_next = 1'b1;
            issued_clock_next   = own_clock;
            dec.issue           = 1'b1;
          end
        end
      end
      pso_pkg::CMD_DELAY_RESP: begin
        if (request_issued && requesting_clock == issued_clock &&
            sequence_id == followup_sequence) begin
          dec.resp = 1'b1;
        end
      end
      pso_pkg::CMD_DELAY_REQ_TX: begin
        dec.upd_departure = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_locked     <= 1'b0;
      master_identity   <= '0;
      sync_sequence     <= '0;
      followup_sequence <= '0;
      request_issued    <= 1'b0;
      issued_clock      <= '0;
    end else if (advance) begin
      master_locked     <= master_locked_next;
      master_identity   <= master_identity_next;
      sync_sequence     <= sync_sequence_next;
      followup_sequence <= followup_sequence_next;
      request_issued    <= request_issued_next;
      issued_clock      <= issued_clock_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ptp_slave_offset_tracker_core.sv
`default_nettype none

// PTPv2 ordinary-clock slave: takes one parsed event request per cycle while item_stall
// is low, and returns delay-request orders and clock offsets in event order. An event
// passes a five-stage pipeline (input register, decision and timestamp multiply,
// timestamp sum and time-state update, delay difference, offset halving) before the
// result register; events that cause no result are dropped at the end. The pipeline
// only holds when the result register is full and stalled, and empty stages close up,
// so a stalled result does not block new events at once.
module ptp_slave_offset_tracker_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               mac_write_enable,
  input  wire logic [47:0]        station_mac,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [2:0]         cmd,
  input  wire logic [15:0]        sequence_id,
  input  wire logic [63:0]        source_clock,
  input  wire logic [63:0]        requesting_clock,
  input  wire logic [7:0]         domain,
  input  wire logic [47:0]        message_seconds,
  input  wire logic [29:0]        message_nanoseconds,
  input  wire logic [63:0]        local_stamp_ns,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    result_kind,
  output logic [15:0]             request_sequence,
  output logic [7:0]              request_domain,
  output logic [63:0]             own_clock,
  output logic signed [63:0]      offset_ns
);

  logic [47:0] mac;

  logic        en1, en2, en3, en4, en5, en_out;

  logic        v1;
  logic [2:0]  cmd1;
  logic [15:0] seq1;
  logic [63:0] src1;
  logic [63:0] req1;
  logic [7:0]  dom1;
  logic [47:0] sec1;
  logic [29:0] ns1;
  logic [63:0] loc1;
  logic [63:0] own1;
  pso_pkg::decision_t dec1;

  logic        v2;
  pso_pkg::decision_t dec2;
  logic [15:0] seq2;
  logic [7:0]  dom2;
  logic [63:0] own2;
  logic [63:0] loc2;
  logic [31:0] pphi2;
  logic [61:0] pplo2;
  logic [29:0] ns2;

  logic        v3;
  pso_pkg::decision_t dec3;
  logic [15:0] seq3;
  logic [7:0]  dom3;
  logic [63:0] own3;
  logic [63:0] loc3;
  logic [63:0] msg3;

  logic [63:0] origin_time;
  logic [63:0] sync_arrival;
  logic [63:0] request_departure;

  logic        v4;
  logic        issue4;
  logic        resp4;
  logic [15:0] seq4;
  logic [7:0]  dom4;
  logic [63:0] own4;
  logic [63:0] diff1_4;
  logic [63:0] diff2_4;

  logic        v5;
  logic        issue5;
  logic        resp5;
  logic [15:0] seq5;
  logic [7:0]  dom5;
  logic [63:0] own5;
  logic [63:0] d5;

  logic [63:0] neg_d5;
  logic [63:0] neg_half5;
  logic [63:0] offset5;

  assign en_out     = !result_valid || !result_stall;
  assign en5        = !v5 || en_out;
  assign en4        = !v4 || en5;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac <= '0;
    end else if (mac_write_enable) begin
      mac <= station_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1 <= cmd;
      seq1 <= sequence_id;
      src1 <= source_clock;
      req1 <= requesting_clock;
      dom1 <= domain;
      sec1 <= message_seconds;
      ns1  <= message_nanoseconds;
      loc1 <= local_stamp_ns;
    end
  end

  assign own1 = pso_pkg::own_identity(mac);

  pso_decide u_decide (
    .clk              (clk),
    .rst              (rst),
    .advance          (v1 && en2),
    .cmd              (cmd1),
    .sequence_id      (seq1),
    .source_clock     (src1),
    .requesting_clock (req1),
    .own_clock        (own1),
    .dec              (dec1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  // Only the low 32 bits of the high product matter, since it is shifted up by 32.
  always_ff @(posedge clk) begin
    if (en2) begin
      dec2  <= dec1;
      seq2  <= seq1;
      dom2  <= dom1;
      own2  <= own1;
      loc2  <= loc1;
      pphi2 <= {16'd0, sec1[47:32]} * {2'd0, pso_pkg::NS_PER_SEC};
      pplo2 <= {30'd0, sec1[31:0]} * {32'd0, pso_pkg::NS_PER_SEC};
      ns2   <= ns1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      dec3 <= dec2;
      seq3 <= seq2;
      dom3 <= dom2;
      own3 <= own2;
      loc3 <= loc2;
      msg3 <= {pphi2, 32'd0} + {2'd0, pplo2} + {34'd0, ns2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_time       <= '0;
      sync_arrival      <= '0;
      request_departure <= '0;
    end else if (v3 && en4) begin
      if (dec3.upd_sync) begin
        sync_arrival <= loc3;
      end
      if (dec3.upd_origin) begin
        origin_time <= msg3;
      end
      if (dec3.issue) begin
        request_departure <= '0;
      end else if (dec3.upd_departure) begin
        request_departure <= loc3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      issue4  <= dec3.issue;
      resp4   <= dec3.resp;
      seq4    <= seq3;
      dom4    <= dom3;
      own4    <= own3;
      diff1_4 <= sync_arrival - origin_time;
      diff2_4 <= msg3 - request_departure;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      issue5 <= issue4;
      resp5  <= resp4;
      seq5   <= seq4;
      dom5   <= dom4;
      own5   <= own4;
      d5     <= diff1_4 - diff2_4;
    end
  end

  // The offset is the negated delay difference halved toward zero.
  assign neg_d5    = 64'd0 - d5;
  assign neg_half5 = 64'd0 - {1'b0, d5[63:1]};
  assign offset5   = neg_d5[63] ? neg_half5 : {1'b0, neg_d5[63:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en_out) begin
      result_valid <= v5 && (issue5 || resp5);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      if (resp5) begin
        result_kind      <= pso_pkg::KIND_OFFSET;
        request_sequence <= '0;
        request_domain   <= '0;
        own_clock        <= '0;
        offset_ns        <= offset5;
      end else begin
        result_kind      <= pso_pkg::KIND_REQUEST;
        request_sequence <= seq5;
        request_domain   <= dom5;
        own_clock        <= own5;
        offset_ns        <= '0;
      end
    end
  end

endmodule

`default_nettype wire
